// ----- design/trd_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// trd_pkg: shared types and constants of the TGA RLE pixel decoder
// Holds packet phases, status codes, register indexes, the controller and
// datapath handshake structs and the pixel reorder function.
// ----------------------------------------------------------------------------
package trd_pkg;

  localparam int CFG_WIDTH  = 32;
  localparam int PAIR_WIDTH = 7;   // up to 64 pixel pairs from one repeat packet

  // Packet phase
  localparam logic [1:0] PH_HEADER  = 2'd0;
  localparam logic [1:0] PH_REPEAT  = 2'd1;
  localparam logic [1:0] PH_LITERAL = 2'd2;

  // Result status
  localparam logic [1:0] ST_PIXELS     = 2'd0;
  localparam logic [1:0] ST_COMPLETE   = 2'd1;
  localparam logic [1:0] ST_INCOMPLETE = 2'd2;
  localparam logic [1:0] ST_BAD_DEPTH  = 2'd3;

  // Configuration register indexes
  localparam logic REG_BPP   = 1'b0;
  localparam logic REG_TOTAL = 1'b1;

  // Supported depths
  localparam logic [7:0] BPP_16    = 8'd16;
  localparam logic [7:0] BPP_24    = 8'd24;
  localparam logic [7:0] BPP_32    = 8'd32;
  localparam logic [7:0] BPP_RESET = 8'd32;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

  typedef struct packed {
    logic step;   // consume the accepted byte
    logic emit;   // load the next result into the output register
  } trd_cmd_t;

  typedef struct packed {
    logic has_result;  // the byte being accepted leaves results to send
    logic pending;     // results of the last byte still wait to be sent
    logic last;        // the next result sent is the last one of its byte
  } trd_sts_t;

  // BGR(A) to RGBA, or pass a 16-bit word through
  function automatic logic [31:0] format_pixel(logic [31:0] raw, logic [7:0] bpp);
    logic [7:0] alpha;
    alpha = (bpp == BPP_24) ? ALPHA_OPAQUE : raw[31:24];
    if (bpp == BPP_16) begin
      return {16'h0000, raw[15:0]};
    end
    return {alpha, raw[7:0], raw[15:8], raw[23:16]};
  endfunction

endpackage
`default_nettype wire

// ----- design/trd_datapath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// trd_datapath: decode state, configuration and result sequencing
// Decodes one source byte per step command and holds the results it causes
// in an emission counter that the emit command drains into the output
// register.
// ----------------------------------------------------------------------------
module trd_datapath #(
  parameter int COUNT_WIDTH = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire trd_pkg::trd_cmd_t             cmd,
  output trd_pkg::trd_sts_t                  sts,
  input  wire logic                          cfg_write,
  input  wire logic                          cfg_index,
  input  wire logic [trd_pkg::CFG_WIDTH-1:0] cfg_data,
  input  wire logic [7:0]                    data_byte,
  input  wire logic                          final_byte,
  input  wire logic                          image_start,
  output logic [31:0]                        pixel_first,
  output logic [31:0]                        pixel_second,
  output logic [1:0]                         pixels_carried,
  output logic                               run_last,
  output logic [1:0]                         status
);
  import trd_pkg::*;

  // Configuration
  logic [7:0]             bpp;
  logic [COUNT_WIDTH-1:0] total;

  // Decode state
  logic [1:0]             phase, phase_next;
  logic [7:0]             left, left_next;
  logic [1:0]             bip, bip_next;
  logic [31:0]            asm_q, asm_next;
  logic [COUNT_WIDTH-1:0] done, done_next;
  logic                   finished, finished_next;
  logic                   error, error_next;

  // Emission state
  logic [31:0]            pix, pix_next;
  logic [PAIR_WIDTH-1:0]  pairs, pairs_next;
  logic                   odd, odd_next;
  logic [1:0]             st, st_next;

  // Values after an image start clear
  logic [1:0]             phase_e, bip_e;
  logic [7:0]             left_e;
  logic [31:0]            asm_e, asm_new;
  logic [COUNT_WIDTH-1:0] done_e, remaining, left_wide;
  logic                   finished_e, error_e;
  logic                   bpp_ok, pix_complete, rep_fits;
  logic [2:0]             nbytes;
  logic [7:0]             n_rep;
  logic                   emit_last;

  always_comb begin
    phase_e    = image_start ? PH_HEADER : phase;
    left_e     = image_start ? 8'd0 : left;
    bip_e      = image_start ? 2'd0 : bip;
    asm_e      = image_start ? 32'd0 : asm_q;
    done_e     = image_start ? '0 : done;
    finished_e = image_start ? 1'b0 : finished;
    error_e    = image_start ? 1'b0 : error;

    bpp_ok       = (bpp == BPP_16) || (bpp == BPP_24) || (bpp == BPP_32);
    nbytes       = bpp[5:3];
    pix_complete = (({1'b0, bip_e}) + 3'd1) >= nbytes;
    asm_new      = asm_e | (32'(data_byte) << {bip_e, 3'b000});
    remaining    = total - done_e;
    left_wide    = COUNT_WIDTH'(left_e);
    rep_fits     = left_wide >= remaining;
    n_rep        = rep_fits ? remaining[7:0] : left_e;

    phase_next    = phase_e;
    left_next     = left_e;
    bip_next      = bip_e;
    asm_next      = asm_e;
    done_next     = done_e;
    finished_next = finished_e;
    error_next    = error_e;
    pix_next      = format_pixel(asm_new, bpp);
    pairs_next    = '0;
    odd_next      = 1'b0;
    st_next       = ST_PIXELS;

    if (!(finished_e || error_e)) begin
      if (done_e >= total) begin
        finished_next = 1'b1;
        st_next       = ST_COMPLETE;
      end else if (!bpp_ok) begin
        error_next = 1'b1;
        st_next    = ST_BAD_DEPTH;
      end else begin
        if (phase_e == PH_HEADER) begin
          left_next  = {1'b0, data_byte[6:0]} + 8'd1;
          bip_next   = 2'd0;
          asm_next   = 32'd0;
          phase_next = data_byte[7] ? PH_REPEAT : PH_LITERAL;
        end else if (pix_complete) begin
          bip_next = 2'd0;
          asm_next = 32'd0;
          if (phase_e == PH_REPEAT) begin
            // drop copies past the total
            done_next     = done_e + COUNT_WIDTH'(n_rep);
            pairs_next    = n_rep[7:1];
            odd_next      = n_rep[0];
            left_next     = 8'd0;
            phase_next    = PH_HEADER;
            finished_next = rep_fits;
          end else begin
            done_next     = done_e + COUNT_WIDTH'(1);
            odd_next      = 1'b1;
            left_next     = (left_e != 8'd0) ? left_e - 8'd1 : 8'd0;
            if (left_e <= 8'd1) begin
              phase_next = PH_HEADER;
            end
            finished_next = (remaining == COUNT_WIDTH'(1));
          end
          if (finished_next) begin
            st_next = ST_COMPLETE;
          end
        end else begin
          bip_next = bip_e + 2'd1;
          asm_next = asm_new;
        end
        if (!finished_next && final_byte) begin
          error_next = 1'b1;
          st_next    = ST_INCOMPLETE;
        end
      end
    end
  end

  assign emit_last      = (pairs == '0) || ((pairs == PAIR_WIDTH'(1)) && !odd);
  assign sts.has_result = (pairs_next != '0) || odd_next || (st_next != ST_PIXELS);
  assign sts.pending    = (pairs != '0) || odd || (st != ST_PIXELS);
  assign sts.last       = emit_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      bpp   <= BPP_RESET;
      total <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_BPP:   bpp   <= cfg_data[7:0];
        REG_TOTAL: total <= cfg_data[COUNT_WIDTH-1:0];
        default:   bpp   <= bpp;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_HEADER;
      left     <= 8'd0;
      bip      <= 2'd0;
      asm_q    <= 32'd0;
      done     <= '0;
      finished <= 1'b0;
      error    <= 1'b0;
    end else if (cmd.step) begin
      phase    <= phase_next;
      left     <= left_next;
      bip      <= bip_next;
      asm_q    <= asm_next;
      done     <= done_next;
      finished <= finished_next;
      error    <= error_next;
    end
  end

  // Emission counter: a new byte's results replace the drained ones
  always_ff @(posedge clk) begin
    if (rst) begin
      pairs <= '0;
      odd   <= 1'b0;
      st    <= ST_PIXELS;
    end else if (cmd.step) begin
      pairs <= pairs_next;
      odd   <= odd_next;
      st    <= st_next;
    end else if (cmd.emit) begin
      if (emit_last) begin
        pairs <= '0;
        odd   <= 1'b0;
        st    <= ST_PIXELS;
      end else begin
        pairs <= pairs - PAIR_WIDTH'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      pix <= pix_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      pixel_first    <= ((pairs != '0) || odd) ? pix : 32'd0;
      pixel_second   <= (pairs != '0) ? pix : 32'd0;
      pixels_carried <= (pairs != '0) ? 2'd2 : (odd ? 2'd1 : 2'd0);
      run_last       <= emit_last;
      status         <= emit_last ? st : ST_PIXELS;
    end
  end

endmodule
`default_nettype wire

// ----- design/trd_controller.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// trd_controller: handshake and result sequencing control
// Accepts a byte when no results wait, or together with the last one,
// and issues emit commands while the output register is free.
// ----------------------------------------------------------------------------
module trd_controller (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output trd_pkg::trd_cmd_t      cmd,
  input  wire trd_pkg::trd_sts_t sts
);
  import trd_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EMIT = 1'b1;

  logic state, state_next;
  logic out_valid_next;
  logic slot_free;

  assign slot_free = !out_valid || out_ready;
  assign cmd.emit  = (state == S_EMIT) && slot_free;
  assign in_ready  = (state == S_IDLE) || (cmd.emit && sts.last);
  assign cmd.step  = in_valid && in_ready;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (cmd.step && sts.has_result) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (cmd.emit && sts.last) begin
          state_next = (cmd.step && sts.has_result) ? S_EMIT : S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // hold the result until taken
  assign out_valid_next = cmd.emit ? 1'b1 : (out_ready ? 1'b0 : out_valid);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

`ifndef SYNTHESIS
  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !sts.pending)
    else $error("idle with results still pending");

  a_emit_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> out_valid)
    else $error("emitted result not presented");

  a_step_emit: assert property (@(posedge clk) disable iff (rst)
    (cmd.step && sts.has_result) |=> (state == S_EMIT) && sts.pending)
    else $error("results of accepted byte not scheduled");
`endif

endmodule
`default_nettype wire

// ----- design/tga_rle_pixel_decoder.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tga_rle_pixel_decoder: run-length coded TGA pixel data decoder
// Takes pixel data bytes, expands repeat and literal packets into RGBA
// pixels or 16-bit words, and reports completion and errors.
// ----------------------------------------------------------------------------
//  channel  signals                                          direction
//  in       in_valid/in_ready, data_byte, final_byte,        sink
//           image_start
//  out      out_valid/out_ready, pixel_first, pixel_second,  source
//           pixels_carried, run_last, status
//  cfg      cfg_write, cfg_index, cfg_data                   sink, no wait
//
//  A byte that causes at most one result does not hold up the next byte
//  unless the output stalls. The byte that closes a repeat pixel waits
//  while the emission counter drains its copies as pixel pairs into the
//  output register. The next byte is accepted in the cycle the last result
//  is loaded. Output stalls hold the emission counter; rst is synchronous
//  and clears decode state, configuration and the output valid.
// ----------------------------------------------------------------------------
module tga_rle_pixel_decoder #(
  parameter int COUNT_WIDTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  data_byte,
  input  wire logic        final_byte,
  input  wire logic        image_start,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      pixel_first,
  output logic [31:0]      pixel_second,
  output logic [1:0]       pixels_carried,
  output logic             run_last,
  output logic [1:0]       status,
  input  wire logic        cfg_write,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_data
);
  import trd_pkg::*;

  trd_cmd_t cmd;
  trd_sts_t sts;

  trd_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  trd_datapath #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .data_byte      (data_byte),
    .final_byte     (final_byte),
    .image_start    (image_start),
    .pixel_first    (pixel_first),
    .pixel_second   (pixel_second),
    .pixels_carried (pixels_carried),
    .run_last       (run_last),
    .status         (status)
  );

endmodule
`default_nettype wire
